// ===== rtl/core/handle_table_engine_defines.svh =====
// Assertion macros for the handle table engine checker.
// Depends on nothing; the including module must provide clock and reset.
`ifndef HANDLE_TABLE_ENGINE_DEFINES_SVH
`define HANDLE_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HTE_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("handle_table_engine check failed");

// Next-cycle implication, disabled while reset is high.
`define HTE_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("handle_table_engine check failed");

`endif

// ===== rtl/core/hte_pkg.sv =====
// Shared types and constants of the handle table engine.
// Depends on nothing.
package hte_pkg;

   localparam int DEF_ENTRIES = 1024;
   localparam int IDX_MAX_W   = 24;
   localparam int HANDLE_W    = 32;
   localparam int OBJ_W       = 16;
   localparam int RIGHTS_W    = 26;
   localparam int FLAG_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int ENTRY_W     = OBJ_W + RIGHTS_W + FLAG_W;
   localparam int FLAG_PROTECT_BIT = 1;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_LOOKUP   = 2'd1,
      CMD_CLOSE    = 2'd2,
      CMD_SETFLAGS = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_INVALID     = 3'd1,
      ST_NORES       = 3'd2,
      ST_NOTCLOSABLE = 3'd3,
      ST_DENIED      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_TRIM_RD,
      S_TRIM_CHK,
      S_RESP
   } state_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      cmd_type                cmd;
      logic                   hvalid;
      logic [IDX_MAX_W-1:0]   idx;
      logic [OBJ_W-1:0]       obj;
      logic [RIGHTS_W-1:0]    acc;
      logic                   inh;
      logic [FLAG_W-1:0]      fmask;
      logic [FLAG_W-1:0]      fval;
      logic                   allow;
   } job_type;

endpackage

// ===== rtl/core/hte_front.sv =====
// Front of the handle table engine: accepts requests, decodes the handle
// and holds them in a two-entry queue. Depends on hte_pkg.
module hte_front
   import hte_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clearing,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [HANDLE_W-1:0]  req_handle,
   input  logic [OBJ_W-1:0]     req_object_id,
   input  logic [RIGHTS_W-1:0]  req_access,
   input  logic                 req_inherit_attr,
   input  logic [FLAG_W-1:0]    req_flag_mask,
   input  logic [FLAG_W-1:0]    req_flag_values,
   input  logic                 req_close_allowed,
   output logic                 job_valid,
   output job_type              job,
   input  logic                 job_pop
);

   localparam int QW = HANDLE_W - 2;
   localparam logic [QW-1:0] ENT_Q = QW'(ENTRIES);

   job_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [QW-1:0] q_num, q_idx;
   job_type     new_job;
   logic        push;

   assign q_num = req_handle[HANDLE_W-1:2];
   assign q_idx = q_num - QW'(1);

   always_comb begin
      new_job.cmd    = cmd_type'(req_cmd);
      new_job.hvalid = (q_num != '0) && (q_idx < ENT_Q);
      new_job.idx    = q_idx[IDX_MAX_W-1:0];
      new_job.obj    = req_object_id;
      new_job.acc    = req_access;
      new_job.inh    = req_inherit_attr;
      new_job.fmask  = req_flag_mask;
      new_job.fval   = req_flag_values;
      new_job.allow  = req_close_allowed;
   end

   assign req_ready = !clearing && (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

// ===== rtl/core/hte_back.sv =====
// Back of the handle table engine: the entry memory, the hint and top
// registers, and the sequencer that executes each request. Depends on hte_pkg.
module hte_back
   import hte_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 clearing,
   input  logic                 job_valid,
   input  job_type              job,
   output logic                 job_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [HANDLE_W-1:0]  rsp_handle_out,
   output logic [OBJ_W-1:0]     rsp_object_out,
   output logic [RIGHTS_W-1:0]  rsp_access_out,
   output logic [FLAG_W-1:0]    rsp_flags_out
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   logic [ENTRY_W-1:0] mem [ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic [CW-1:0] hint_ff, hint_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] ptr_ff, ptr_in;

   status_type          res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [OBJ_W-1:0]    res_obj_ff, res_obj_in;
   logic [RIGHTS_W-1:0] res_acc_ff, res_acc_in;
   logic [FLAG_W-1:0]   res_flags_ff, res_flags_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [OBJ_W-1:0]    rsp_obj_ff;
   logic [RIGHTS_W-1:0] rsp_acc_ff;
   logic [FLAG_W-1:0]   rsp_flags_ff;

   logic               mem_we;
   logic [IW-1:0]      mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [OBJ_W-1:0]    rd_obj;
   logic [RIGHTS_W-1:0] rd_acc;
   logic [FLAG_W-1:0]   rd_flags, new_flags;
   logic [IW-1:0]       jidx;
   logic [CW-1:0]       jidx_c, ptr_next, top_prev;
   logic                in_range, out_free, denied, refused;
   logic [HANDLE_W-1:0] grant_handle;

   assign rd_obj   = rd_data_ff[ENTRY_W-1 -: OBJ_W];
   assign rd_acc   = rd_data_ff[FLAG_W +: RIGHTS_W];
   assign rd_flags = rd_data_ff[FLAG_W-1:0];

   assign jidx      = job_ff.idx[IW-1:0];
   assign jidx_c    = CW'(jidx);
   assign in_range  = job_ff.hvalid && (jidx_c < top_ff);
   assign ptr_next  = ptr_ff + CW'(1);
   assign top_prev  = top_ff - CW'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign denied    = (rd_acc & job_ff.acc) != job_ff.acc;
   assign refused   = rd_flags[FLAG_PROTECT_BIT] || !job_ff.allow;
   assign new_flags = (rd_flags & ~job_ff.fmask) | (job_ff.fval & job_ff.fmask);
   assign grant_handle = HANDLE_W'({ptr_next, 2'b00});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (ptr_ff == LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (job_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (job_ff.cmd == CMD_ALLOC) begin
               state_in = (job_ff.obj == '0) ? S_RESP : S_SCAN_RD;
            end else begin
               state_in = in_range ? S_CHECK : S_RESP;
            end
         end
         S_SCAN_RD: begin
            state_in = (ptr_ff < top_ff) ? S_SCAN_CHK : S_RESP;
         end
         S_SCAN_CHK: begin
            state_in = (rd_obj == '0) ? S_RESP : S_SCAN_RD;
         end
         S_CHECK: begin
            if (rd_obj != '0 && job_ff.cmd == CMD_CLOSE && !refused &&
                jidx_c == top_prev) begin
               state_in = S_TRIM_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_TRIM_RD: begin
            state_in = (top_ff == '0) ? S_RESP : S_TRIM_CHK;
         end
         S_TRIM_CHK: begin
            state_in = (rd_obj == '0) ? S_TRIM_RD : S_RESP;
         end
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Outputs of the sequencer: memory controls, register updates, result.
   always_comb begin
      clearing      = (state_ff == S_CLEAR);
      job_pop       = 1'b0;
      job_in        = job_ff;
      hint_in       = hint_ff;
      top_in        = top_ff;
      ptr_in        = ptr_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff[IW-1:0];
      mem_wdata     = '0;
      mem_raddr     = ptr_ff[IW-1:0];
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_obj_in    = res_obj_ff;
      res_acc_in    = res_acc_ff;
      res_flags_in  = res_flags_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_next;
         end
         S_IDLE: begin
            job_pop = job_valid;
            job_in  = job;
         end
         S_DISPATCH: begin
            res_status_in = ST_INVALID;
            res_handle_in = '0;
            res_obj_in    = '0;
            res_acc_in    = '0;
            res_flags_in  = '0;
            ptr_in        = hint_ff;
            mem_raddr     = jidx;
         end
         S_SCAN_RD: begin
            if (ptr_ff < top_ff) begin
               // Read the slot; the verdict comes next cycle.
            end else if (ptr_ff >= FULL) begin
               res_status_in = ST_NORES;
            end else begin
               top_in        = ptr_next;
               hint_in       = ptr_next;
               mem_we        = 1'b1;
               mem_wdata     = {job_ff.obj, job_ff.acc, 1'b0, job_ff.inh};
               res_status_in = ST_OK;
               res_handle_in = grant_handle;
            end
         end
         S_SCAN_CHK: begin
            if (rd_obj == '0) begin
               hint_in       = ptr_next;
               mem_we        = 1'b1;
               mem_wdata     = {job_ff.obj, job_ff.acc, 1'b0, job_ff.inh};
               res_status_in = ST_OK;
               res_handle_in = grant_handle;
            end else begin
               ptr_in = ptr_next;
            end
         end
         S_CHECK: begin
            mem_waddr = jidx;
            if (rd_obj != '0) begin
               case (job_ff.cmd)
                  CMD_LOOKUP: begin
                     if (denied) begin
                        res_status_in = ST_DENIED;
                     end else begin
                        res_status_in = ST_OK;
                        res_obj_in    = rd_obj;
                        res_acc_in    = rd_acc;
                        res_flags_in  = rd_flags;
                     end
                  end
                  CMD_CLOSE: begin
                     if (refused) begin
                        res_status_in = ST_NOTCLOSABLE;
                     end else begin
                        res_status_in = ST_OK;
                        mem_we        = 1'b1;
                        mem_wdata     = {{OBJ_W{1'b0}}, rd_acc, rd_flags};
                        if (jidx_c < hint_ff) hint_in = jidx_c;
                        if (jidx_c == top_prev) top_in = top_prev;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                     res_flags_in  = rd_flags;
                     mem_we        = 1'b1;
                     mem_wdata     = {rd_obj, rd_acc, new_flags};
                  end
               endcase
            end
         end
         S_TRIM_RD: begin
            mem_raddr = top_prev[IW-1:0];
         end
         S_TRIM_CHK: begin
            if (rd_obj == '0) top_in = top_prev;
         end
         S_RESP: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         hint_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         hint_ff      <= hint_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_obj_ff    <= res_obj_in;
      res_acc_ff    <= res_acc_in;
      res_flags_ff  <= res_flags_in;
      if (state_ff == S_RESP && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_obj_ff    <= res_obj_ff;
         rsp_acc_ff    <= res_acc_ff;
         rsp_flags_ff  <= res_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_object_out = rsp_obj_ff;
   assign rsp_access_out = rsp_acc_ff;
   assign rsp_flags_out  = rsp_flags_ff;

endmodule

// ===== rtl/core/handle_table_engine.sv =====
// Handle table engine. Lookup, set flags and close read and check the addressed slot; allocate
// scans occupied slots from the free hint and reuses the first hole or appends at the top, and
// a close of the top slot trims further empty slots until an occupied one or an empty table.
// One request executes at a time.
// Reset is synchronous; a clearing pass then writes all ENTRIES slots with req_ready low.
module handle_table_engine
   import hte_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [HANDLE_W-1:0]  req_handle,
   input  logic [OBJ_W-1:0]     req_object_id,
   input  logic [RIGHTS_W-1:0]  req_access,
   input  logic                 req_inherit_attr,
   input  logic [FLAG_W-1:0]    req_flag_mask,
   input  logic [FLAG_W-1:0]    req_flag_values,
   input  logic                 req_close_allowed,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [HANDLE_W-1:0]  rsp_handle_out,
   output logic [OBJ_W-1:0]     rsp_object_out,
   output logic [RIGHTS_W-1:0]  rsp_access_out,
   output logic [FLAG_W-1:0]    rsp_flags_out
);

   // The front decodes each request transaction's handle into a slot index
   // and a range flag and parks it in a two-entry queue, so new transactions
   // are taken while the back is still busy or a result waits to be taken.
   logic    clearing;
   logic    job_valid;
   logic    job_pop;
   job_type job;

   hte_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .clearing          (clearing),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_handle        (req_handle),
      .req_object_id     (req_object_id),
      .req_access        (req_access),
      .req_inherit_attr  (req_inherit_attr),
      .req_flag_mask     (req_flag_mask),
      .req_flag_values   (req_flag_values),
      .req_close_allowed (req_close_allowed),
      .job_valid         (job_valid),
      .job               (job),
      .job_pop           (job_pop)
   );

   // The back owns the entry memory, the free hint and the used top. It
   // scans for free slots on allocate, checks occupancy and rights, and
   // trims the used range after a close of the top slot. Results leave
   // through an output register that holds until the response is taken.
   hte_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .job_valid      (job_valid),
      .job            (job),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_object_out (rsp_object_out),
      .rsp_access_out (rsp_access_out),
      .rsp_flags_out  (rsp_flags_out)
   );

endmodule

// ===== rtl/core/hte_checker.sv =====
// Port-level checks of the handle table engine, bound to the top level.
// Depends on hte_pkg and handle_table_engine_defines.svh.
`include "handle_table_engine_defines.svh"

module hte_checker
   import hte_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [HANDLE_W-1:0]  rsp_handle_out,
   input logic [OBJ_W-1:0]     rsp_object_out,
   input logic [RIGHTS_W-1:0]  rsp_access_out,
   input logic [FLAG_W-1:0]    rsp_flags_out
);

   `HTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `HTE_ASSERT_NOW(a_fail_zero, rsp_valid && rsp_status != ST_OK, rsp_handle_out == '0 && rsp_object_out == '0 && rsp_access_out == '0 && rsp_flags_out == '0)
   `HTE_ASSERT_NOW(a_alloc_shape, rsp_valid && rsp_handle_out != '0, rsp_handle_out[1:0] == 2'b00 && rsp_object_out == '0 && rsp_status == ST_OK)
   `HTE_ASSERT_NOW(a_status_code, rsp_valid, rsp_status <= ST_DENIED)

endmodule

bind handle_table_engine hte_checker u_hte_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_handle_out (rsp_handle_out),
   .rsp_object_out (rsp_object_out),
   .rsp_access_out (rsp_access_out),
   .rsp_flags_out  (rsp_flags_out)
);

// ===== dv/handle_table_engine_tb.sv =====
// Self-checking testbench for the handle table engine: allocate, lookup, close, set flags.
// Depends on hte_pkg and the handle_table_engine RTL; a local table model predicts responses.
module handle_table_engine_tb;
   import hte_pkg::*;

   localparam int SLOTS = DEF_ENTRIES;

   // One request transaction as queued for the driver.
   typedef struct {
      cmd_type               cmd;
      logic [HANDLE_W-1:0]   handle;
      logic [OBJ_W-1:0]      obj;
      logic [RIGHTS_W-1:0]   acc;
      logic                  inh;
      logic [FLAG_W-1:0]     fmask;
      logic [FLAG_W-1:0]     fval;
      logic                  allow;
   } req_item_t;

   // One response transaction as the table should return it.
   typedef struct {
      status_type            status;
      logic [HANDLE_W-1:0]   handle;
      logic [OBJ_W-1:0]      obj;
      logic [RIGHTS_W-1:0]   acc;
      logic [FLAG_W-1:0]     flags;
   } rsp_item_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_cmd = CMD_ALLOC;
   logic [HANDLE_W-1:0]  req_handle = '0;
   logic [OBJ_W-1:0]     req_object_id = '0;
   logic [RIGHTS_W-1:0]  req_access = '0;
   logic                 req_inherit_attr = 1'b0;
   logic [FLAG_W-1:0]    req_flag_mask = '0;
   logic [FLAG_W-1:0]    req_flag_values = '0;
   logic                 req_close_allowed = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [HANDLE_W-1:0]  rsp_handle_out;
   logic [OBJ_W-1:0]     rsp_object_out;
   logic [RIGHTS_W-1:0]  rsp_access_out;
   logic [FLAG_W-1:0]    rsp_flags_out;

   handle_table_engine #(.ENTRIES(SLOTS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_handle(req_handle), .req_object_id(req_object_id), .req_access(req_access),
      .req_inherit_attr(req_inherit_attr), .req_flag_mask(req_flag_mask),
      .req_flag_values(req_flag_values), .req_close_allowed(req_close_allowed),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_handle_out(rsp_handle_out), .rsp_object_out(rsp_object_out),
      .rsp_access_out(rsp_access_out), .rsp_flags_out(rsp_flags_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   req_item_t pending_reqs[$];
   rsp_item_t expected_rsps[$];
   int        mismatches = 0;
   bit        sender_hold = 1'b0;
   bit        hold_armed = 1'b0;

   // Shadow copy of the handle table, updated as each request is accepted.
   logic [OBJ_W-1:0]    shadow_obj[SLOTS];
   logic [RIGHTS_W-1:0] shadow_rights[SLOTS];
   logic [FLAG_W-1:0]   shadow_flags[SLOTS];
   int unsigned         shadow_hint = 0;
   int unsigned         shadow_top = 0;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         shadow_obj[i] = '0;
         shadow_rights[i] = '0;
         shadow_flags[i] = '0;
      end
   end

   // Apply one request to the shadow table and return the response it must produce.
   function automatic rsp_item_t apply_request(req_item_t r);
      rsp_item_t   o;
      int unsigned q;
      int unsigned i;
      bit          hit;
      bit          found;
      o = '{status: ST_OK, handle: '0, obj: '0, acc: '0, flags: '0};
      // Decode the handle: zero-based slot, empty and out-of-range slots are invalid.
      q = r.handle >> 2;
      hit = (q != 0);
      q = q - 1;
      if (hit && (q >= shadow_top || q >= SLOTS)) hit = 1'b0;
      if (hit && shadow_obj[q] == '0) hit = 1'b0;
      if (r.cmd == CMD_ALLOC) begin
         if (r.obj == '0) begin
            o.status = ST_INVALID;
         end else begin
            i = shadow_hint;
            found = 1'b0;
            while (i < shadow_top && i < SLOTS) begin
               if (shadow_obj[i] == '0) begin
                  found = 1'b1;
                  break;
               end
               i++;
            end
            if (!found && i >= SLOTS) begin
               o.status = ST_NORES;
            end else begin
               if (!found) shadow_top = i + 1;
               shadow_hint = i + 1;
               shadow_obj[i] = r.obj;
               shadow_rights[i] = r.acc;
               shadow_flags[i] = {1'b0, r.inh};
               o.handle = (i + 1) << 2;
            end
         end
      end else if (!hit) begin
         o.status = ST_INVALID;
      end else if (r.cmd == CMD_LOOKUP) begin
         if ((shadow_rights[q] & r.acc) != r.acc) begin
            o.status = ST_DENIED;
         end else begin
            o.obj = shadow_obj[q];
            o.acc = shadow_rights[q];
            o.flags = shadow_flags[q];
         end
      end else if (r.cmd == CMD_CLOSE) begin
         if (shadow_flags[q][FLAG_PROTECT_BIT] || !r.allow) begin
            o.status = ST_NOTCLOSABLE;
         end else begin
            shadow_obj[q] = '0;
            if (q < shadow_hint) shadow_hint = q;
            // Closing the top slot pulls the used range down over any empty slots.
            if (q + 1 == shadow_top) begin
               while (shadow_top > 0 && shadow_obj[shadow_top - 1] == '0) shadow_top--;
            end
         end
      end else begin
         o.flags = shadow_flags[q];
         shadow_flags[q] = (shadow_flags[q] & ~r.fmask) | (r.fval & r.fmask);
      end
      return o;
   endfunction

   // Driver: works in bursts, idles in random gaps, and honors the sender hold.
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      req_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0 || sender_hold || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            it = pending_reqs.pop_front();
            req_cmd <= it.cmd;
            req_handle <= it.handle;
            req_object_id <= it.obj;
            req_access <= it.acc;
            req_inherit_attr <= it.inh;
            req_flag_mask <= it.fmask;
            req_flag_values <= it.fval;
            req_close_allowed <= it.allow;
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Predict at the accepting edge, from the values the driver has been holding.
   always @(posedge clock) begin
      req_item_t r;
      if (!reset && req_valid && req_ready) begin
         r.cmd = cmd_type'(req_cmd);
         r.handle = req_handle;
         r.obj = req_object_id;
         r.acc = req_access;
         r.inh = req_inherit_attr;
         r.fmask = req_flag_mask;
         r.fval = req_flag_values;
         r.allow = req_close_allowed;
         expected_rsps.push_back(apply_request(r));
      end
   end

   // Receiver: switches at random among its stall modes. Once the stimulus arms it, it holds
   // off for a long stretch so the engine backs up and stops accepting requests.
   int rx_cycle = 0;
   int rx_mode = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_armed && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 600;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // Monitor: each response transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_item_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing expected, actual status %h", $time,
                     rsp_status);
         end else begin
            e = expected_rsps.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("handle_out", e.handle, rsp_handle_out);
            check_field("object_out", e.obj, rsp_object_out);
            check_field("access_out", e.acc, rsp_access_out);
            check_field("flags_out", e.flags, rsp_flags_out);
         end
      end
   end

   task automatic push_req(cmd_type c, logic [31:0] h, logic [15:0] ob, logic [25:0] ac,
                           logic ih, logic [1:0] fm, logic [1:0] fv, logic al);
      req_item_t r;
      r = '{cmd: c, handle: h, obj: ob, acc: ac, inh: ih, fmask: fm, fval: fv, allow: al};
      pending_reqs.push_back(r);
   endtask

   // Handle aimed at slots 0..span, with stray low bits and occasional wild values.
   function automatic logic [31:0] pick_handle(int span);
      int sel;
      sel = $urandom_range(0, 31);
      if (sel == 0) return $urandom_range(0, 3);
      if (sel < 3) return $urandom;
      return (($urandom_range(0, span) + 1) << 2) | $urandom_range(0, 3);
   endfunction

   function automatic logic [25:0] pick_rights();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return '0;
         2: return 26'($urandom & $urandom & $urandom);
         default: return 26'($urandom);
      endcase
   endfunction

   task automatic push_random(int span, int alloc_weight);
      cmd_type c;
      logic [15:0] ob;
      if ($urandom_range(0, 99) < alloc_weight) c = CMD_ALLOC;
      else c = cmd_type'($urandom_range(1, 3));
      ob = ($urandom_range(0, 31) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
      push_req(c, pick_handle(span), ob, pick_rights(), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
               $urandom_range(0, 3) != 0);
   endtask

   // Let every queued request go out, then hold the sender until every response is back.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid)
         @(posedge clock);
      sender_hold = 1'b1;
      while (expected_rsps.size() != 0)
         @(posedge clock);
      sender_hold = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: the corner cases of every command on a near-empty table.
      push_req(CMD_ALLOC, 0, 16'd0, '1, 1, 0, 0, 1);          // object zero is refused
      push_req(CMD_ALLOC, 0, 16'hFFFF, '1, 1, 0, 0, 1);       // slot 0, all rights
      push_req(CMD_ALLOC, '1, 16'd1, '0, 0, 3, 3, 0);          // slot 1, no rights
      push_req(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 1);               // null handle
      push_req(CMD_LOOKUP, 3, 0, 0, 0, 0, 0, 1);               // below the first handle
      push_req(CMD_LOOKUP, 32'h7, 0, '1, 0, 0, 0, 1);          // low bits ignored
      push_req(CMD_LOOKUP, 32'h8, 0, 26'd1, 0, 0, 0, 1);       // rights missing
      push_req(CMD_LOOKUP, 32'hC, 0, 0, 0, 0, 0, 1);           // past the used range
      push_req(CMD_LOOKUP, '1, 0, 0, 0, 0, 0, 1);              // largest handle
      push_req(CMD_SETFLAGS, 32'h8, 0, 0, 0, 3, 2, 1);         // protect slot 1
      push_req(CMD_CLOSE, 32'h8, 0, 0, 0, 0, 0, 1);            // protected, refused
      push_req(CMD_SETFLAGS, 32'h8, 0, 0, 0, 2, 0, 1);         // unprotect
      push_req(CMD_CLOSE, 32'h8, 0, 0, 0, 0, 0, 0);            // object veto
      push_req(CMD_CLOSE, 32'h4, 0, 0, 0, 0, 0, 1);            // close slot 0, hint drops
      push_req(CMD_LOOKUP, 32'h4, 0, 0, 0, 0, 0, 1);           // empty slot
      push_req(CMD_ALLOC, 0, 16'h1234, 26'h2AAAAAA, 0, 0, 0, 1); // reuses slot 0
      push_req(CMD_ALLOC, 0, 16'h8000, 26'h1555555, 1, 0, 0, 1);
      push_req(CMD_ALLOC, 0, 16'h0001, 26'h0000001, 0, 0, 0, 1);
      push_req(CMD_CLOSE, 32'hC, 0, 0, 0, 0, 0, 1);            // hole below the top
      push_req(CMD_CLOSE, 32'h10, 0, 0, 0, 0, 0, 1);           // top close trims the hole
      push_req(CMD_CLOSE, 32'h8, 0, 0, 0, 0, 0, 1);
      push_req(CMD_SETFLAGS, 32'h4, 0, 0, 0, 0, 3, 1);         // empty mask
      push_req(CMD_CLOSE, 32'h4, 0, 0, 0, 0, 0, 1);            // table empties
      drain();

      // Random traffic on a small table, then fill it to the brim with a few
      // requests on top, then random traffic across the full handle space.
      repeat (150) push_random(40, 35);
      drain();
      repeat (1100) begin
         if ($urandom_range(0, 31) == 0) push_random(SLOTS - 1, 0);
         else push_random(SLOTS - 1, 100);
      end
      repeat (100) push_random(SLOTS - 1, 30);
      hold_armed = 1'b1;
      drain();

      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== handle_table_engine.f =====
+incdir+rtl/core
rtl/core/hte_pkg.sv
rtl/core/hte_front.sv
rtl/core/hte_back.sv
rtl/core/handle_table_engine.sv
rtl/core/hte_checker.sv
dv/handle_table_engine_tb.sv
